// File: src/bdqs_pkg.sv
// Package for the bounded deque with search.
// Holds the operation codes, status codes and the result struct shared by
// the sequencer and the top level. It depends on nothing.
package bdqs_pkg;

  localparam int unsigned ValueW = 32;

  localparam logic [1:0] FN_INS_FRONT = 2'd0;
  localparam logic [1:0] FN_INS_BACK  = 2'd1;
  localparam logic [1:0] FN_REM_BACK  = 2'd2;
  localparam logic [1:0] FN_SEARCH    = 2'd3;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [ValueW-1:0] removed_value;
  } res_t;

endpackage

// File: src/bdqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry store of the deque; depends on nothing.
module bdqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bdqs_ctrl.sv
// Sequencer of the deque: ring pointers, entry count and the shared
// equality comparator that walks the entries during a search.
// Depends on bdqs_pkg and drives the ports of a bdqs_ram instance.
module bdqs_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_func,
  input  logic [bdqs_pkg::ValueW-1:0] in_value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output bdqs_pkg::res_t             res,
  output logic [$clog2(DEPTH+1)-1:0] res_count,
  output logic                       ram_we,
  output logic [$clog2(DEPTH)-1:0]   ram_waddr,
  output logic [bdqs_pkg::ValueW-1:0] ram_wdata,
  output logic [$clog2(DEPTH)-1:0]   ram_raddr,
  input  logic [bdqs_pkg::ValueW-1:0] ram_rdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RDW  = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [AW-1:0]               front_r, front_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]               issued_r, issued_nxt;
  logic [bdqs_pkg::ValueW-1:0] key_r, key_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        found_r, found_nxt;
  logic [bdqs_pkg::ValueW-1:0] removed_r, removed_nxt;

  logic          full;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] front_dec;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign cnt_m1    = count_r - CW'(1);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);

  assign in_ready      = (state_r == ST_IDLE);
  assign res_valid     = (state_r == ST_RES);
  assign res.status        = status_r;
  assign res.found         = found_r;
  assign res.removed_value = removed_r;
  assign res_count     = count_r;
  assign ram_wdata     = in_value;

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    rd_ptr_nxt  = rd_ptr_r;
    issued_nxt  = issued_r;
    key_nxt     = key_r;
    status_nxt  = status_r;
    found_nxt   = found_r;
    removed_nxt = removed_r;
    ram_we      = 1'b0;
    ram_waddr   = front_r;
    ram_raddr   = rd_ptr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          status_nxt  = bdqs_pkg::STS_OK;
          found_nxt   = 1'b0;
          removed_nxt = '0;
          state_nxt   = ST_RES;
          unique case (in_func)
            bdqs_pkg::FN_INS_FRONT: begin
              if (full) begin
                status_nxt = bdqs_pkg::STS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            bdqs_pkg::FN_INS_BACK: begin
              if (full) begin
                status_nxt = bdqs_pkg::STS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(front_r, count_r[AW-1:0]);
                count_nxt = count_r + CW'(1);
              end
            end
            bdqs_pkg::FN_REM_BACK: begin
              if (count_r == '0) begin
                status_nxt = bdqs_pkg::STS_EMPTY;
              end else begin
                ram_raddr = wrap_add(front_r, cnt_m1[AW-1:0]);
                count_nxt = cnt_m1;
                state_nxt = ST_RDW;
              end
            end
            bdqs_pkg::FN_SEARCH: begin
              key_nxt = in_value;
              if (count_r != '0) begin
                ram_raddr  = front_r;
                rd_ptr_nxt = wrap_add(front_r, AW'(1));
                issued_nxt = CW'(1);
                state_nxt  = ST_SRCH;
              end
            end
          endcase
        end
      end
      ST_RDW: begin
        removed_nxt = ram_rdata;
        state_nxt   = ST_RES;
      end
      ST_SRCH: begin
        if (ram_rdata == key_r) begin
          found_nxt = 1'b1;
          state_nxt = ST_RES;
        end else if (issued_r == count_r) begin
          state_nxt = ST_RES;
        end else begin
          rd_ptr_nxt = wrap_add(rd_ptr_r, AW'(1));
          issued_nxt = issued_r + CW'(1);
        end
      end
      ST_RES: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
    rd_ptr_r  <= rd_ptr_nxt;
    issued_r  <= issued_nxt;
    key_r     <= key_nxt;
    status_r  <= status_nxt;
    found_r   <= found_nxt;
    removed_r <= removed_nxt;
  end

endmodule

// File: src/bounded_deque_with_search.sv
// Top level of the bounded deque with search.
// Instantiates bdqs_ctrl and bdqs_ram and holds the output register;
// depends on bdqs_pkg.
//
//   channel  | direction | tdata (low bit up)                    | tuser
//   ---------+-----------+---------------------------------------+-----------
//   in_      | slave     | value[31:0]                           | func[1:0]
//   out_     | master    | status, found, removed_value, count   | none
//
// A search compares the entries from the front one at a time and stops
// at the first match or after the last entry: the single RAM read port
// feeds one comparator. On an empty store it compares nothing.
// Reset clears the front pointer and count; the entry RAM is not cleared.
// The output register lets a new transaction start while a result waits.
module bounded_deque_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,  // value[31:0]
  input  logic [1:0]           in_tuser,  // func[1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // status[1:0], found, removed_value[31:0], count_now[CW-1:0], zero pad
  output logic [(((35 + $clog2(DEPTH + 1)) + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W = (((35 + CW) + 7) / 8) * 8;

  logic                        res_valid;
  logic                        res_ready;
  bdqs_pkg::res_t              res;
  logic [CW-1:0]               res_count;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [bdqs_pkg::ValueW-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [bdqs_pkg::ValueW-1:0] ram_rdata;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  bdqs_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_value  (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .res_count (res_count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bdqs_ram #(
    .WIDTH(bdqs_pkg::ValueW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_data_r <= OUT_W'({res_count, res.removed_value, res.found, res.status});
    end
  end

endmodule

// File: verif/tb.sv
// Self-checking testbench for bounded_deque_with_search, driving its stream ports.
// Needs src/bdqs_pkg.sv and the RTL; a built-in deque predictor checks most results.
// The run is a directed table, then random phases with sender gaps and receiver stalls.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = 64;
  localparam int PtrW   = $clog2(DEPTH);
  localparam int CountW = $clog2(DEPTH + 1);
  localparam int OutW   = ((35 + CountW + 7) / 8) * 8;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [31:0]       removed;
    logic [CountW-1:0] count;
  } outcome_t;

  typedef struct {
    logic [1:0] fn;
    logic [31:0] val;
    bit          typed;
    outcome_t    want;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutW-1:0] out_tdata;

  logic [31:0] ring_store [DEPTH];
  logic [PtrW-1:0] front_slot = '0;
  logic [CountW-1:0] fill_level = '0;

  outcome_t pending_outcomes[$];
  int fault_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_cycles_req = 0;
  int hold_served = 0;

  probe_t probes [22] = '{
    '{bdqs_pkg::FN_REM_BACK,  32'h0000_0000, 1'b1,
      '{bdqs_pkg::STS_EMPTY, 1'b0, 32'h0000_0000, 7'd0}},
    '{bdqs_pkg::FN_SEARCH,    32'h0000_0000, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'h0000_0000, 7'd0}},
    '{bdqs_pkg::FN_INS_FRONT, 32'h8000_0000, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'h0000_0000, 7'd1}},
    '{bdqs_pkg::FN_INS_BACK,  32'h7fff_ffff, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'h0000_0000, 7'd2}},
    '{bdqs_pkg::FN_SEARCH,    32'h8000_0000, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b1, 32'h0000_0000, 7'd2}},
    '{bdqs_pkg::FN_SEARCH,    32'h7fff_ffff, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b1, 32'h0000_0000, 7'd2}},
    '{bdqs_pkg::FN_SEARCH,    32'h0000_0000, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'h0000_0000, 7'd2}},
    '{bdqs_pkg::FN_INS_FRONT, 32'hffff_ffff, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'h0000_0000, 7'd3}},
    '{bdqs_pkg::FN_INS_BACK,  32'h0000_0000, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'h0000_0000, 7'd4}},
    '{bdqs_pkg::FN_SEARCH,    32'hffff_ffff, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b1, 32'h0000_0000, 7'd4}},
    '{bdqs_pkg::FN_REM_BACK,  32'h1234_5678, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'h0000_0000, 7'd3}},
    '{bdqs_pkg::FN_REM_BACK,  32'h0000_0000, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'h7fff_ffff, 7'd2}},
    '{bdqs_pkg::FN_REM_BACK,  32'h0000_0000, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'h8000_0000, 7'd1}},
    '{bdqs_pkg::FN_REM_BACK,  32'h0000_0000, 1'b1,
      '{bdqs_pkg::STS_OK, 1'b0, 32'hffff_ffff, 7'd0}},
    '{bdqs_pkg::FN_REM_BACK,  32'hffff_ffff, 1'b1,
      '{bdqs_pkg::STS_EMPTY, 1'b0, 32'h0000_0000, 7'd0}},
    '{bdqs_pkg::FN_INS_BACK,  32'h5555_5555, 1'b0, '0},
    '{bdqs_pkg::FN_INS_FRONT, 32'haaaa_aaaa, 1'b0, '0},
    '{bdqs_pkg::FN_SEARCH,    32'h5555_5555, 1'b0, '0},
    '{bdqs_pkg::FN_SEARCH,    32'h5555_5554, 1'b0, '0},
    '{bdqs_pkg::FN_REM_BACK,  32'h0000_0000, 1'b0, '0},
    '{bdqs_pkg::FN_SEARCH,    32'h5555_5555, 1'b0, '0},
    '{bdqs_pkg::FN_REM_BACK,  32'h0000_0000, 1'b0, '0}
  };

  bounded_deque_with_search #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic outcome_t deque_apply(input logic [1:0] fn, input logic [31:0] val);
    outcome_t r;
    logic [PtrW-1:0] slot;
    int k;
    r = '0;
    r.status = bdqs_pkg::STS_OK;
    case (fn)
      bdqs_pkg::FN_INS_FRONT, bdqs_pkg::FN_INS_BACK: begin
        if (fill_level == DEPTH) begin
          r.status = bdqs_pkg::STS_FULL;
        end else if (fn == bdqs_pkg::FN_INS_FRONT) begin
          front_slot = front_slot - 1'b1;
          ring_store[front_slot] = val;
          fill_level = fill_level + 1'b1;
        end else begin
          slot = front_slot + fill_level[PtrW-1:0];
          ring_store[slot] = val;
          fill_level = fill_level + 1'b1;
        end
      end
      bdqs_pkg::FN_REM_BACK: begin
        if (fill_level == 0) begin
          r.status = bdqs_pkg::STS_EMPTY;
        end else begin
          slot = front_slot + fill_level[PtrW-1:0] - 1'b1;
          r.removed = ring_store[slot];
          fill_level = fill_level - 1'b1;
        end
      end
      default: begin
        for (k = 0; k < fill_level; k++) begin
          slot = front_slot + k[PtrW-1:0];
          if (ring_store[slot] == val) r.found = 1'b1;
        end
      end
    endcase
    r.count = fill_level;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(7);
    case (r)
      0: begin
        case ($urandom_range(4))
          0: return 32'h0000_0000;
          1: return 32'h8000_0000;
          2: return 32'h7fff_ffff;
          3: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2, 3: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_search_value();
    logic [PtrW-1:0] slot;
    if (fill_level != 0 && $urandom_range(1) == 1) begin
      slot = front_slot + PtrW'($urandom_range(fill_level - 1));
      return ring_store[slot];
    end
    return pick_value();
  endfunction

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("%s", what);
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = out_tdata[1:0];
      got.found   = out_tdata[2];
      got.removed = out_tdata[34:3];
      got.count   = out_tdata[35 +: CountW];
      if (pending_outcomes.size() == 0) begin
        note_fault($sformatf("unexpected result: status %0d found %0d removed %h count %0d",
                             got.status, got.found, got.removed, got.count));
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          note_fault($sformatf({"mismatch: expected status %0d found %0d removed %h ",
                                "count %0d, got status %0d found %0d removed %h count %0d"},
                               want.status, want.found, want.removed, want.count,
                               got.status, got.found, got.removed, got.count));
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_served < hold_cycles_req) begin
      out_tready <= 1'b0;
      hold_served <= hold_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic push_item(input logic [1:0] fn, input logic [31:0] val, input bit typed,
                           input outcome_t want);
    outcome_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= fn;
    do @(posedge clk); while (!in_tready);
    pred = deque_apply(fn, val);
    pending_outcomes.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items);
    logic [1:0] fn;
    int r;
    int mode;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      mode = (i / 110) % 4;
      r = $urandom_range(99);
      case (mode)
        0, 2: fn = (r < 40) ? bdqs_pkg::FN_INS_FRONT :
                   (r < 78) ? bdqs_pkg::FN_INS_BACK :
                   (r < 88) ? bdqs_pkg::FN_REM_BACK : bdqs_pkg::FN_SEARCH;
        3: fn = (r < 8) ? bdqs_pkg::FN_INS_FRONT :
                (r < 16) ? bdqs_pkg::FN_INS_BACK :
                (r < 80) ? bdqs_pkg::FN_REM_BACK : bdqs_pkg::FN_SEARCH;
        default: fn = 2'(r % 4);
      endcase
      push_item(fn, (fn == bdqs_pkg::FN_SEARCH) ? pick_search_value() : pick_value(),
                1'b0, '0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (probes[i]) begin
      push_item(probes[i].fn, probes[i].val, probes[i].typed, probes[i].want);
    end
    wait_drained();
    run_phase(0, 0, 400);
    run_phase(65, 0, 400);
    run_phase(0, 65, 400);
    run_phase(29, 29, 400);
    hold_cycles_req <= hold_cycles_req + 400;
    run_phase(0, 0, 150);
    repeat (DEPTH + 20) @(posedge clk);
    if (fault_count == 0 && pending_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
